@@ hdl/concatenated_segment_mapper_assert.svh @@
// assertion macros for the segment mapper
`ifndef CONCATENATED_SEGMENT_MAPPER_ASSERT_SVH
`define CONCATENATED_SEGMENT_MAPPER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment mapper assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment mapper assertion failed");

`endif

@@ hdl/csm_pkg.sv @@
package csm_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int RESULT_CAP       = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam int LEN_W  = 31;
    localparam int REQ_W  = 32;
    localparam int OFF_W  = 32;
    localparam int IDX_W  = 4;
    localparam int ACT_W  = 2;
    localparam int ORG_W  = 2;
    localparam int N_W    = $clog2(RESULT_CAP);

    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEEK   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

    localparam logic [ORG_W-1:0] ORG_START  = 2'd0;
    localparam logic [ORG_W-1:0] ORG_CURSOR = 2'd1;
    localparam logic [ORG_W-1:0] ORG_END    = 2'd2;
    localparam logic [ORG_W-1:0] ORG_BAD    = 2'd3;

    typedef enum logic [2:0] {
        CMD_APPEND,
        CMD_SEEK,
        CMD_READ,
        CMD_NOP,
        CMD_REJECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [LEN_W-1:0]  seg_len;
        logic [ORG_W-1:0]  origin;
        logic [OFF_W-1:0]  offset;
        logic [REQ_W-1:0]  want;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } back_state_t;

endpackage

@@ hdl/csm_if.sv @@
interface csm_in_if;
    logic                              valid;
    logic                              ready;
    logic [csm_pkg::ACT_W-1:0]         action;
    logic [csm_pkg::LEN_W-1:0]         segment_length;
    logic [csm_pkg::ORG_W-1:0]         seek_origin;
    logic signed [csm_pkg::OFF_W-1:0]  seek_offset;
    logic [csm_pkg::REQ_W-1:0]         request_bytes;

    modport source (
        output valid, action, segment_length, seek_origin, seek_offset, request_bytes,
        input  ready
    );
    modport sink (
        input  valid, action, segment_length, seek_origin, seek_offset, request_bytes,
        output ready
    );
endinterface

interface csm_out_if;
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [csm_pkg::IDX_W-1:0] segment_index;
    logic [csm_pkg::LEN_W-1:0] segment_offset;
    logic [csm_pkg::LEN_W-1:0] chunk_length;
    logic [csm_pkg::LEN_W-1:0] cursor;
    logic [csm_pkg::REQ_W-1:0] bytes_done;
    logic                      last;

    modport source (
        output valid, status, segment_index, segment_offset, chunk_length, cursor,
               bytes_done, last,
        input  ready
    );
    modport sink (
        input  valid, status, segment_index, segment_offset, chunk_length, cursor,
               bytes_done, last,
        output ready
    );
endinterface

@@ hdl/concatenated_segment_mapper.sv @@
// channel  dir  transfer payload
// cmd      in   action, segment_length, seek_origin, seek_offset, request_bytes
// res      out  status, segment_index, segment_offset, chunk_length, cursor,
//               bytes_done, last
//
// an item enters a two-entry command queue; append, seek and no-op items are
// then completed by the back end in its idle state, each loading one result
// a read walks the segment table from entry 0 to the entry that holds the
// cursor, then for each chunk does one table read and one result load
// the walk is set by the single read port of the segment table
// reset clears segment count, total and cursor; the table needs no clearing
// either side may stall: the queue and the result register decouple them
module concatenated_segment_mapper #(
    parameter int MAX_SEGMENTS = csm_pkg::MAX_SEGMENTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    csm_in_if.sink    cmd,
    csm_out_if.source res
);

    csm_pkg::queue_head_t head;
    logic                 pop;

    csm_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head),
        .pop   (pop)
    );

    csm_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

@@ hdl/csm_ram.sv @@
module csm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/csm_front.sv @@
module csm_front (
    input  logic                clk,
    input  logic                rst_n,
    csm_in_if.sink              cmd,
    output csm_pkg::queue_head_t head,
    input  logic                pop
);

    localparam int PW = (csm_pkg::QUEUE_DEPTH > 1) ? $clog2(csm_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(csm_pkg::QUEUE_DEPTH + 1);

    csm_pkg::cmd_t   q_mem_reg [csm_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    csm_pkg::cmd_t   cls;
    logic            push;

    // classify the incoming item
    always_comb
    begin
        cls.seg_len = cmd.segment_length;
        cls.origin  = cmd.seek_origin;
        cls.offset  = cmd.seek_offset;
        cls.want    = cmd.request_bytes;
        unique case (cmd.action)
            csm_pkg::ACT_APPEND: cls.kind = csm_pkg::CMD_APPEND;
            csm_pkg::ACT_SEEK:
            begin
                cls.kind = (cmd.seek_origin == csm_pkg::ORG_BAD) ?
                           csm_pkg::CMD_REJECT : csm_pkg::CMD_SEEK;
            end
            csm_pkg::ACT_READ:
            begin
                // zero-byte read gives the same single result as a no-op
                cls.kind = (cmd.request_bytes == '0) ? csm_pkg::CMD_NOP : csm_pkg::CMD_READ;
            end
            default: cls.kind = csm_pkg::CMD_NOP;
        endcase
    end

    assign cmd.ready  = (cnt_reg != CW'(csm_pkg::QUEUE_DEPTH));
    assign push       = cmd.valid && cmd.ready;
    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(csm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(csm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ hdl/csm_back.sv @@
`include "concatenated_segment_mapper_assert.svh"

module csm_back #(
    parameter int MAX_SEGMENTS = csm_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csm_pkg::queue_head_t head,
    output logic                 pop,
    csm_out_if.source            res
);

    localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int L   = csm_pkg::LEN_W;
    localparam int RW  = 2 * csm_pkg::LEN_W;

    csm_pkg::back_state_t state_reg, state_next;

    logic [IW-1:0]           idx_reg, idx_next;
    logic [IW:0]             count_reg, count_next;
    logic [L-1:0]            total_reg, total_next;
    logic [L-1:0]            cursor_reg, cursor_next;
    logic [csm_pkg::REQ_W-1:0] got_reg, got_next;
    logic [csm_pkg::REQ_W-1:0] rem_reg, rem_next;
    logic [csm_pkg::N_W-1:0] n_reg, n_next;
    logic [L-1:0]            in_seg_reg, in_seg_next;
    logic [L-1:0]            avail_reg, avail_next;
    logic                    end_tot_reg, end_tot_next;

    logic                    out_valid_reg;
    logic                    out_free;
    logic                    res_load;
    logic                    res_status;
    logic [csm_pkg::IDX_W-1:0] res_index;
    logic [L-1:0]            res_offset;
    logic [L-1:0]            res_chunk;
    logic [csm_pkg::REQ_W-1:0] res_done;
    logic                    res_last;
    logic                    status_reg;
    logic [csm_pkg::IDX_W-1:0] index_reg;
    logic [L-1:0]            offset_reg, chunk_reg, cur_out_reg;
    logic [csm_pkg::REQ_W-1:0] done_reg;
    logic                    last_reg;

    logic                    ram_we;
    logic [RW-1:0]           ram_rdata;
    logic [L-1:0]            seg_start, seg_end;
    logic                    hit;

    logic [L:0]              app_sum;
    logic                    app_reject;
    logic [L-1:0]            seek_base;
    logic [L+2:0]            seek_target;
    logic                    seek_reject;
    logic                    rem_le;
    logic                    chunk_last;
    logic [L-1:0]            chunk;

    // segment table: start and end offset of each segment
    csm_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IW-1:0]),
        .wdata ({total_reg, app_sum[L-1:0]}),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    assign seg_start = ram_rdata[RW-1:L];
    assign seg_end   = ram_rdata[L-1:0];
    assign hit       = (cursor_reg >= seg_start) && (cursor_reg < seg_end);
    assign out_free  = !out_valid_reg || res.ready;

    assign app_sum    = {1'b0, total_reg} + {1'b0, head.cmd.seg_len};
    assign app_reject = (count_reg >= (IW + 1)'(MAX_SEGMENTS)) || app_sum[L];

    always_comb
    begin
        unique case (head.cmd.origin)
            csm_pkg::ORG_START:  seek_base = '0;
            csm_pkg::ORG_CURSOR: seek_base = cursor_reg;
            csm_pkg::ORG_END:    seek_base = total_reg;
            default:             seek_base = '0;
        endcase
    end

    assign seek_target = {3'b000, seek_base} + {{2{head.cmd.offset[csm_pkg::OFF_W-1]}},
                                                head.cmd.offset};
    assign seek_reject = (seek_target[L+2:L] != 3'b000);

    assign rem_le     = (rem_reg <= {1'b0, avail_reg});
    assign chunk      = rem_le ? rem_reg[L-1:0] : avail_reg;
    assign chunk_last = rem_le || end_tot_reg || (n_reg == csm_pkg::N_W'(csm_pkg::RESULT_CAP - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csm_pkg::ST_IDLE:
            begin
                if (head.valid && out_free && head.cmd.kind == csm_pkg::CMD_READ &&
                    cursor_reg < total_reg)
                begin
                    state_next = csm_pkg::ST_SCAN;
                end
            end
            csm_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = csm_pkg::ST_EMIT;
                end
            end
            csm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = chunk_last ? csm_pkg::ST_IDLE : csm_pkg::ST_SCAN;
                end
            end
            default: state_next = csm_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop          = 1'b0;
        ram_we       = 1'b0;
        idx_next     = idx_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        cursor_next  = cursor_reg;
        got_next     = got_reg;
        rem_next     = rem_reg;
        n_next       = n_reg;
        in_seg_next  = in_seg_reg;
        avail_next   = avail_reg;
        end_tot_next = end_tot_reg;
        res_load     = 1'b0;
        res_status   = 1'b0;
        res_index    = '0;
        res_offset   = '0;
        res_chunk    = '0;
        res_done     = '0;
        res_last     = 1'b1;
        unique case (state_reg)
            csm_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (head.valid && out_free)
                begin
                    unique case (head.cmd.kind)
                        csm_pkg::CMD_APPEND:
                        begin
                            pop        = 1'b1;
                            res_load   = 1'b1;
                            res_status = app_reject;
                            if (!app_reject)
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                total_next = app_sum[L-1:0];
                            end
                        end
                        csm_pkg::CMD_SEEK:
                        begin
                            pop        = 1'b1;
                            res_load   = 1'b1;
                            res_status = seek_reject;
                            if (!seek_reject)
                            begin
                                cursor_next = seek_target[L-1:0];
                            end
                        end
                        csm_pkg::CMD_READ:
                        begin
                            if (cursor_reg >= total_reg)
                            begin
                                pop      = 1'b1;
                                res_load = 1'b1;
                            end
                            else
                            begin
                                got_next = '0;
                                rem_next = head.cmd.want;
                                n_next   = '0;
                            end
                        end
                        csm_pkg::CMD_NOP:
                        begin
                            pop      = 1'b1;
                            res_load = 1'b1;
                        end
                        csm_pkg::CMD_REJECT:
                        begin
                            pop        = 1'b1;
                            res_load   = 1'b1;
                            res_status = 1'b1;
                        end
                        default:
                        begin
                            pop      = 1'b1;
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            csm_pkg::ST_SCAN:
            begin
                in_seg_next  = cursor_reg - seg_start;
                avail_next   = seg_end - cursor_reg;
                end_tot_next = (seg_end == total_reg);
                if (!hit)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            csm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    res_load    = 1'b1;
                    res_index   = csm_pkg::IDX_W'(idx_reg);
                    res_offset  = in_seg_reg;
                    res_chunk   = chunk;
                    got_next    = got_reg + {1'b0, chunk};
                    rem_next    = rem_reg - {1'b0, chunk};
                    cursor_next = cursor_reg + chunk;
                    n_next      = n_reg + 1'b1;
                    res_done    = got_next;
                    res_last    = chunk_last;
                    if (chunk_last)
                    begin
                        pop = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csm_pkg::ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            cursor_reg <= cursor_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        got_reg     <= got_next;
        rem_reg     <= rem_next;
        n_reg       <= n_next;
        in_seg_reg  <= in_seg_next;
        avail_reg   <= avail_next;
        end_tot_reg <= end_tot_next;
        if (res_load)
        begin
            status_reg  <= res_status;
            index_reg   <= res_index;
            offset_reg  <= res_offset;
            chunk_reg   <= res_chunk;
            cur_out_reg <= cursor_next;
            done_reg    <= res_done;
            last_reg    <= res_last;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.status         = status_reg;
    assign res.segment_index  = index_reg;
    assign res.segment_offset = offset_reg;
    assign res.chunk_length   = chunk_reg;
    assign res.cursor         = cur_out_reg;
    assign res.bytes_done     = done_reg;
    assign res.last           = last_reg;

    `CSM_ASSERT_IMP(a_load_into_free_slot, res_load, out_free)
    `CSM_ASSERT_IMP(a_scan_below_count, state_reg == csm_pkg::ST_SCAN, {1'b0, idx_reg} < count_reg)
    `CSM_ASSERT_IMP(a_chunk_nonzero, (state_reg == csm_pkg::ST_EMIT) && res_load, res_chunk != '0)
    `CSM_ASSERT_NEXT(a_total_grows, 1'b1, total_reg >= $past(total_reg))

endmodule
